@@ rtl/anrt_pkg.sv @@
// Package for the ACK/NACK reorder tracker: widths, response codes and defaults.
// Has no dependencies; used by every module of the block.
`default_nettype none
package anrt_pkg;
	localparam int SLOTS_DEF = 64;
	localparam int SEQ_W = 32;
	localparam int LEN_W = 16;
	localparam int LIM_W = 4;
	localparam int SLOT_OUT_W = 6;
	localparam logic [LIM_W-1:0] RETRY_LIMIT_RST = 4'd2;
	localparam int IN_W = 56;
	localparam int OUT_W = 80;

	typedef enum logic [1:0] {
		RESP_NONE = 2'd0,
		RESP_ACK = 2'd1,
		RESP_NACK = 2'd2
	} resp_t;

	// Result of one scan over the slot table.
	typedef struct packed {
		logic match_hit;
		logic match_cnt;
		logic free_hit;
	} scan_res_t;
endpackage
`default_nettype wire

@@ rtl/anrt_table.sv @@
// Slot table memory with one shared sequence comparator and a scan walker.
// Depends on anrt_pkg. Valid and counter flags are flip-flops; fields are RAM.
`default_nettype none
module anrt_table #(
	parameter int SLOTS = anrt_pkg::SLOTS_DEF,
	parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic scan_start,
	input wire logic [anrt_pkg::SEQ_W-1:0] key,
	output logic scan_done,
	output anrt_pkg::scan_res_t res,
	output logic [IW-1:0] match_idx,
	output logic [IW-1:0] free_idx,
	output logic [anrt_pkg::LEN_W-1:0] match_val,
	input wire logic wr_en,
	input wire logic [IW-1:0] wr_idx,
	input wire logic wr_cnt,
	input wire logic [anrt_pkg::SEQ_W-1:0] wr_seq,
	input wire logic [anrt_pkg::LEN_W-1:0] wr_val,
	input wire logic clr_en,
	input wire logic [IW-1:0] clr_idx
);
	import anrt_pkg::*;

	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] cnt_q;
	logic [SEQ_W-1:0] seq_mem [SLOTS];
	logic [LEN_W-1:0] val_mem [SLOTS];

	logic busy_q, rd_v_q, last_q;
	logic [IW:0] ptr_q;
	logic [IW-1:0] rd_idx_q;
	logic [SEQ_W-1:0] rd_seq_q;
	logic [LEN_W-1:0] rd_val_q;
	logic rd_ok;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seq_mem[wr_idx] <= wr_seq;
			val_mem[wr_idx] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_seq_q <= seq_mem[ptr_q[IW-1:0]];
		rd_val_q <= val_mem[ptr_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
				cnt_q[wr_idx] <= wr_cnt;
			end
			if (clr_en) begin
				valid_q[clr_idx] <= 1'b0;
			end
		end
	end

	assign rd_ok = rd_v_q && valid_q[rd_idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_v_q <= 1'b0;
			last_q <= 1'b0;
			ptr_q <= '0;
			rd_idx_q <= '0;
			res <= '0;
			match_idx <= '0;
			free_idx <= '0;
			match_val <= '0;
			scan_done <= 1'b0;
		end else begin
			scan_done <= 1'b0;
			if (scan_start) begin
				busy_q <= 1'b1;
				ptr_q <= '0;
				rd_v_q <= 1'b0;
				last_q <= 1'b0;
				res <= '0;
			end else begin
				if (busy_q) begin
					rd_v_q <= 1'b1;
					rd_idx_q <= ptr_q[IW-1:0];
					last_q <= (ptr_q == (IW+1)'(SLOTS-1));
					if (ptr_q == (IW+1)'(SLOTS-1)) begin
						busy_q <= 1'b0;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end else begin
					rd_v_q <= 1'b0;
				end
				if (rd_v_q) begin
					if (rd_ok && !res.match_hit && rd_seq_q == key) begin
						res.match_hit <= 1'b1;
						res.match_cnt <= cnt_q[rd_idx_q];
						match_idx <= rd_idx_q;
						match_val <= rd_val_q;
					end
					if (!valid_q[rd_idx_q] && !res.free_hit) begin
						res.free_hit <= 1'b1;
						free_idx <= rd_idx_q;
					end
					if (last_q) begin
						scan_done <= 1'b1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/ack_nack_reorder_tracker_unit.sv @@
// Top level of the ACK/NACK reorder tracker: stream ports, sequencer, result register.
// Depends on anrt_pkg and anrt_table.
//
// Each item starts one scan of the slot table: the table walker reads one slot per
// cycle through a single comparator, so the result of an item is registered after the
// walk has read every slot and the table has raised scan_done, at the same edge that
// applies the table update. s_tready is low while an item is at work and while its
// result waits; it rises the cycle after the result is taken, so a new item is not
// accepted before the result of the last one has been taken. A packet item
// finds the lowest valid slot whose sequence equals its seq and the lowest free slot
// in that scan; a drain item looks up the running byte offset the same way. One
// result item is produced per input item and held in the output register until taken.
`default_nettype none
module ack_nack_reorder_tracker_unit #(
	parameter int SLOTS = anrt_pkg::SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: seq[31:0], length[47:32], crc_ok[48], fin[49], zero fill
	input wire logic [anrt_pkg::IN_W-1:0] s_tdata,
	// tuser: kind
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: response[1:0], ack_seq[33:2], stored[34], slot_index[40:35],
	// transfer_done[41], drain_found[42], chunk_length[58:43], packet_count[74:59],
	// zero fill
	output logic [anrt_pkg::OUT_W-1:0] m_tdata,
	input wire logic cfg_we,
	input wire logic [anrt_pkg::LIM_W-1:0] cfg_wdata
);
	import anrt_pkg::*;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_t;
	state_t state_q;

	logic [LIM_W-1:0] limit_q;
	logic kind_q, crc_q, fin_q;
	logic [SEQ_W-1:0] seq_q, offset_q;
	logic [LEN_W-1:0] len_q, count_q;
	logic done_q;

	logic scan_start, scan_done;
	scan_res_t res;
	logic [IW-1:0] match_idx, free_idx;
	logic [LEN_W-1:0] match_val;
	logic [SEQ_W-1:0] key;

	logic wr_en, wr_cnt, clr_en;
	logic [IW-1:0] wr_idx;
	logic [LEN_W-1:0] wr_val;

	assign s_tready = (state_q == ST_IDLE);
	assign scan_start = s_tvalid && s_tready;
	// Drain looks for the next in-order offset; packets look for their own seq.
	assign key = s_tuser ? offset_q : s_tdata[31:0];

	logic [SEQ_W-1:0] key_q;
	always_ff @(posedge clk) begin
		if (scan_start) begin
			key_q <= key;
		end
	end

	anrt_table #(.SLOTS(SLOTS), .IW(IW)) u_table (
		.clk, .arst_n, .scan_start, .key(key_q), .scan_done, .res,
		.match_idx, .free_idx, .match_val,
		.wr_en, .wr_idx, .wr_cnt, .wr_seq(seq_q), .wr_val,
		.clr_en, .clr_idx(match_idx)
	);

	// Decision logic for the finished scan.
	logic cur_cnt, nack, drain_hit, counted;
	logic [LEN_W-1:0] r_count;
	resp_t r_resp;
	logic r_stored;
	logic [IW-1:0] r_slot;
	always_comb begin
		cur_cnt = res.match_hit && res.match_cnt;
		nack = !kind_q && !crc_q && (cur_cnt ? match_val : '0) < LEN_W'(limit_q);
		drain_hit = kind_q && res.match_hit && !res.match_cnt;
		wr_en = 1'b0;
		wr_idx = free_idx;
		wr_cnt = 1'b0;
		wr_val = len_q;
		clr_en = 1'b0;
		counted = 1'b0;
		r_stored = 1'b0;
		r_slot = '0;
		r_resp = RESP_NONE;
		if (kind_q) begin
			clr_en = drain_hit;
			if (drain_hit) begin
				r_slot = match_idx;
			end
		end else if (nack) begin
			r_resp = RESP_NACK;
			if (res.match_hit) begin
				wr_en = 1'b1;
				wr_idx = match_idx;
				wr_cnt = res.match_cnt;
				wr_val = match_val + 1'b1;
			end else begin
				wr_en = res.free_hit;
				wr_cnt = 1'b1;
				wr_val = LEN_W'(1);
			end
		end else begin
			r_resp = RESP_ACK;
			if (cur_cnt) begin
				wr_en = 1'b1;
				wr_idx = match_idx;
				r_stored = 1'b1;
				r_slot = match_idx;
				counted = 1'b1;
			end else if (res.match_hit) begin
				counted = 1'b1;
			end else if (res.free_hit) begin
				wr_en = 1'b1;
				r_stored = 1'b1;
				r_slot = free_idx;
				counted = 1'b1;
			end
		end
		if (state_q != ST_SCAN || !scan_done) begin
			wr_en = 1'b0;
			clr_en = 1'b0;
		end
		r_count = (counted && count_q != '1) ? count_q + 1'b1 : count_q;
	end

	logic [SLOT_OUT_W-1:0] slot_out;
	assign slot_out = SLOT_OUT_W'({{SLOT_OUT_W{1'b0}}, r_slot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= RETRY_LIMIT_RST;
			offset_q <= '0;
			done_q <= 1'b0;
			count_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			kind_q <= 1'b0;
			crc_q <= 1'b0;
			fin_q <= 1'b0;
			seq_q <= '0;
			len_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (scan_start) begin
						kind_q <= s_tuser;
						seq_q <= s_tdata[31:0];
						len_q <= s_tdata[47:32];
						crc_q <= s_tdata[48];
						fin_q <= s_tdata[49];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						logic nd;
						nd = done_q || (r_resp == RESP_ACK && fin_q);
						done_q <= nd;
						count_q <= r_count;
						if (drain_hit) begin
							offset_q <= offset_q + SEQ_W'(match_val);
						end
						m_tdata <= {5'd0, r_count, (drain_hit ? match_val : '0), drain_hit,
							nd, slot_out, r_stored,
							((r_resp == RESP_NONE) ? '0 : seq_q), r_resp};
						m_tvalid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/anrt_checker.sv @@
// Port-level checker for the ACK/NACK reorder tracker, bound to the top level.
// Depends on anrt_pkg and ack_nack_reorder_tracker_unit.
`default_nettype none
module anrt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [anrt_pkg::OUT_W-1:0] m_tdata
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready during work");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input open with result pending");
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad response code");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata[41] ##1 m_tvalid |-> m_tdata[41])
		else $error("done flag dropped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
endmodule

bind ack_nack_reorder_tracker_unit anrt_checker u_anrt_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the ACK/NACK reorder tracker: drives packet and drain items,
// predicts every result with a behavioral table model and compares field by field.
// Depends on anrt_pkg and ack_nack_reorder_tracker_unit.
`timescale 1ns / 100ps
module testbench;
	import anrt_pkg::*;

	localparam int NSLOT = 64;

	typedef struct packed {
		logic kind;
		logic [31:0] seq;
		logic [15:0] length;
		logic crc_ok;
		logic fin;
	} pkt_item_t;

	typedef struct packed {
		resp_t response;
		logic [31:0] ack_seq;
		logic stored;
		logic [5:0] slot_index;
		logic transfer_done;
		logic drain_found;
		logic [15:0] chunk_length;
		logic [15:0] packet_count;
	} tracker_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [LIM_W-1:0] cfg_wdata = '0;

	ack_nack_reorder_tracker_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the slot table and the running transfer state.
	logic slot_valid [NSLOT];
	logic slot_is_counter [NSLOT];
	logic [31:0] slot_seq [NSLOT];
	logic [15:0] slot_len_or_count [NSLOT];
	logic [31:0] expect_offset;
	logic expect_done;
	logic [15:0] expect_accepted;
	logic [3:0] shadow_retry_limit;
	logic [31:0] expect_offset_guess = '0;

	pkt_item_t pending_items[$];
	tracker_result_t expected_results[$];
	int mismatch_count = 0;
	// While quiet is set neither side idles.
	logic quiet = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int lookup_seq(input logic [31:0] s);
		for (int i = 0; i < NSLOT; i++)
			if (slot_valid[i] && slot_seq[i] == s)
				return i;
		return -1;
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < NSLOT; i++)
			if (!slot_valid[i])
				return i;
		return -1;
	endfunction

	// Applies one accepted item to the shadow table and returns the result it causes.
	function automatic tracker_result_t track_item(input pkt_item_t it);
		tracker_result_t r;
		int idx;
		int fr;
		logic accept;
		logic counted;
		logic [15:0] count;
		r = '0;
		r.response = RESP_NONE;
		if (!it.kind) begin
			accept = 1'b1;
			idx = lookup_seq(it.seq);
			if (!it.crc_ok) begin
				count = (idx >= 0 && slot_is_counter[idx]) ? slot_len_or_count[idx] : 16'd0;
				if (count < {12'd0, shadow_retry_limit}) begin
					accept = 1'b0;
					r.response = RESP_NACK;
					r.ack_seq = it.seq;
					if (idx < 0) begin
						fr = lowest_free();
						if (fr >= 0) begin
							slot_valid[fr] = 1'b1;
							slot_is_counter[fr] = 1'b1;
							slot_seq[fr] = it.seq;
							slot_len_or_count[fr] = 16'd1;
						end
					end else begin
						// Bumps the field even when the match is a data slot.
						slot_len_or_count[idx] = slot_len_or_count[idx] + 16'd1;
					end
				end
			end
			if (accept) begin
				counted = 1'b0;
				fr = (idx >= 0) ? idx : lowest_free();
				if (idx >= 0 && !slot_is_counter[idx]) begin
					counted = 1'b1;  // duplicate of a stored packet
				end else if (fr >= 0) begin
					slot_valid[fr] = 1'b1;
					slot_is_counter[fr] = 1'b0;
					slot_seq[fr] = it.seq;
					slot_len_or_count[fr] = it.length;
					r.stored = 1'b1;
					r.slot_index = fr[5:0];
					counted = 1'b1;
				end
				if (counted && expect_accepted != 16'hFFFF)
					expect_accepted++;
				r.response = RESP_ACK;
				r.ack_seq = it.seq;
				if (it.fin)
					expect_done = 1'b1;
			end
		end else begin
			idx = lookup_seq(expect_offset);
			if (idx >= 0 && !slot_is_counter[idx]) begin
				r.drain_found = 1'b1;
				r.chunk_length = slot_len_or_count[idx];
				r.slot_index = idx[5:0];
				expect_offset = expect_offset + {16'd0, slot_len_or_count[idx]};
				slot_valid[idx] = 1'b0;
			end
		end
		r.transfer_done = expect_done;
		r.packet_count = expect_accepted;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Driver: presents the queue head and predicts its result when it is taken.
	// A presented item stays unchanged until it is accepted.
	always @(posedge clk) begin
		pkt_item_t cur;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				cur = pending_items.pop_front();
				expected_results.push_back(track_item(cur));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
					cur = pending_items[0];
					s_tvalid <= 1'b1;
					s_tuser <= cur.kind;
					s_tdata <= {6'd0, cur.fin, cur.crc_ok, cur.length, cur.seq};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= quiet || $urandom_range(99) >= 6;
		end
	end

	// Monitor: compares each taken result with the oldest prediction.
	always @(posedge clk) begin
		tracker_result_t got;
		tracker_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.response = resp_t'(m_tdata[1:0]);
			got.ack_seq = m_tdata[33:2];
			got.stored = m_tdata[34];
			got.slot_index = m_tdata[40:35];
			got.transfer_done = m_tdata[41];
			got.drain_found = m_tdata[42];
			got.chunk_length = m_tdata[58:43];
			got.packet_count = m_tdata[74:59];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_results.pop_front();
				if (got.response != want.response)
					report_mismatch("response", got.response, want.response);
				if (got.ack_seq != want.ack_seq)
					report_mismatch("ack_seq", got.ack_seq, want.ack_seq);
				if (got.stored != want.stored)
					report_mismatch("stored", got.stored, want.stored);
				if (got.slot_index != want.slot_index)
					report_mismatch("slot_index", got.slot_index, want.slot_index);
				if (got.transfer_done != want.transfer_done)
					report_mismatch("transfer_done", got.transfer_done, want.transfer_done);
				if (got.drain_found != want.drain_found)
					report_mismatch("drain_found", got.drain_found, want.drain_found);
				if (got.chunk_length != want.chunk_length)
					report_mismatch("chunk_length", got.chunk_length, want.chunk_length);
				if (got.packet_count != want.packet_count)
					report_mismatch("packet_count", got.packet_count, want.packet_count);
			end
		end
	end

	function automatic pkt_item_t make_pkt(input logic [31:0] s, input logic [15:0] l,
			input logic ok, input logic f);
		pkt_item_t it;
		it.kind = 1'b0;
		it.seq = s;
		it.length = l;
		it.crc_ok = ok;
		it.fin = f;
		return it;
	endfunction

	function automatic pkt_item_t make_drain();
		pkt_item_t it;
		it = '0;
		it.kind = 1'b1;
		it.seq = $urandom();
		it.length = 16'($urandom());
		it.crc_ok = 1'($urandom_range(1));
		it.fin = 1'($urandom_range(1));
		return it;
	endfunction

	// Waits until every queued item has produced its result, then lets the block settle.
	task automatic wait_idle();
		while (pending_items.size() > 0 || expected_results.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_retry_limit(input logic [3:0] lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		shadow_retry_limit = lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One well-formed transfer: in-order chunks, some with bad checksums, with bad copies
	// of random chunks and drains mixed in, then drains that walk the running offset.
	task automatic queue_transfer(input int chunks);
		logic [31:0] base;
		logic [31:0] seqs[$];
		logic [15:0] lens[$];
		int j;
		int k;
		base = expect_offset_guess;
		for (j = 0; j < chunks; j++) begin
			seqs.push_back(base);
			lens.push_back(($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 1500)));
			base = base + {16'd0, lens[j]};
		end
		expect_offset_guess = base;
		for (j = 0; j < chunks; j++) begin
			k = $urandom_range(chunks - 1);
			if ($urandom_range(3) == 0)
				pending_items.push_back(make_pkt(seqs[k], lens[k], 1'b0, 1'b0));
			if ($urandom_range(5) == 0)
				pending_items.push_back(make_drain());
			pending_items.push_back(make_pkt(seqs[j], lens[j], $urandom_range(4) != 0,
				j == chunks - 1));
		end
		for (j = 0; j < chunks + 1; j++)
			pending_items.push_back(make_drain());
	endtask

	initial begin
		int n;
		for (int i = 0; i < NSLOT; i++) begin
			slot_valid[i] = 1'b0;
			slot_is_counter[i] = 1'b0;
			slot_seq[i] = '0;
			slot_len_or_count[i] = '0;
		end
		expect_offset = '0;
		expect_done = 1'b0;
		expect_accepted = '0;
		shadow_retry_limit = RETRY_LIMIT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset limit: drain of an empty table, NACK then
		// acceptance at the limit, duplicates, zero-length chunk, field extremes.
		pending_items.push_back(make_drain());
		pending_items.push_back(make_pkt(32'd0, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(make_pkt(32'd0, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(make_drain());
		pending_items.push_back(make_pkt(32'd0, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(make_pkt(32'd0, 16'd16, 1'b1, 1'b0));
		pending_items.push_back(make_drain());
		pending_items.push_back(make_pkt(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1));
		pending_items.push_back(make_pkt(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0));
		pending_items.push_back(make_pkt(32'hFFFF_FFFF, 16'h0001, 1'b0, 1'b0));
		pending_items.push_back(make_pkt(32'h5555_5555, 16'hAAAA, 1'b1, 1'b0));
		pending_items.push_back(make_pkt(32'hAAAA_AAAA, 16'h5555, 1'b0, 1'b1));
		pending_items.push_back(make_drain());
		pending_items.push_back(make_drain());
		wait_idle();

		// Limit zero: bad packets are accepted at once.
		write_retry_limit(4'd0);
		pending_items.push_back(make_pkt(32'h0000_0001, 16'd7, 1'b0, 1'b1));
		pending_items.push_back(make_pkt(32'h0000_0001, 16'd7, 1'b0, 1'b0));
		expect_offset_guess = expect_offset;
		queue_transfer(6);
		wait_idle();

		// Highest limit, then fill the table past full with no drains.
		write_retry_limit(4'd15);
		for (int i = 0; i < 70; i++)
			pending_items.push_back(make_pkt($urandom(), 16'($urandom()),
				$urandom_range(7) != 0, 1'($urandom_range(1))));
		wait_idle();
		for (int i = 0; i < 20; i++)
			pending_items.push_back(make_pkt(32'h1234_0000, 16'd3, 1'b0, 1'b0));
		pending_items.push_back(make_drain());
		wait_idle();

		// Random phases: mostly coherent transfers, some noise, with varying limits.
		// The table is emptied by a reset-free path only through drains, so the
		// offset follows what the shadow says.
		quiet = 1'b1;
		n = 0;
		while (n < 420) begin
			if (n == 120)
				quiet = 1'b0;
			if ($urandom_range(7) == 0) begin
				wait_idle();
				write_retry_limit(4'($urandom_range(15)));
			end
			expect_offset_guess = expect_offset;
			if ($urandom_range(4) == 0) begin
				repeat (4) begin
					pending_items.push_back($urandom_range(2) == 0 ? make_drain() :
						make_pkt($urandom_range(1) ? $urandom() : expect_offset,
							16'($urandom()), 1'($urandom_range(1)),
							1'($urandom_range(1))));
				end
				n += 4;
			end else begin
				queue_transfer($urandom_range(1, 8));
				n += 12;
			end
			wait_idle();
		end
		wait_idle();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Overall limit: ends the run with a mismatch report if the test has not finished.
	initial begin
		#(12 * 4000000);
		$display("end of test: mismatches");
		$finish;
	end
endmodule

@@ ack_nack_reorder_tracker_unit.f @@
rtl/anrt_pkg.sv
rtl/anrt_table.sv
rtl/ack_nack_reorder_tracker_unit.sv
rtl/anrt_checker.sv
bench/testbench.sv
